// ===== rtl/twsl_pkg.sv =====
// shared constants, types and codes for the tach window shift light block
// used by twsl_classify and tach_window_shift_light_core; no dependencies
`timescale 1ns / 1ps

package twsl_pkg;

   // averaging window, a power of two so the average is a plain shift
   localparam int AVG_SAMPLES = 16;
   localparam int AVG_SHIFT   = $clog2(AVG_SAMPLES);
   localparam int CNT_W       = AVG_SHIFT;
   localparam int PERIOD_W    = 16;
   localparam int SUM_W       = PERIOD_W + AVG_SHIFT;

   // dimming
   localparam int DIM_LEVELS     = 8;
   localparam int LEVEL_W        = 3;
   localparam int PHASE_W        = DIM_LEVELS - 1;
   localparam int LEVEL_AT_RESET = (3 < DIM_LEVELS) ? 3 : DIM_LEVELS - 1;

   // button
   localparam int HOLD_W       = 16;
   localparam int REPEAT_RESET = 6000;

   // lamp codes
   localparam int LAMP_W = 4;
   localparam logic [LAMP_W-1:0] LAMP_NONE   = 4'h0;
   localparam logic [LAMP_W-1:0] LAMP_YELLOW = 4'h1;
   localparam logic [LAMP_W-1:0] LAMP_GREEN  = 4'h2;
   localparam logic [LAMP_W-1:0] LAMP_RED    = 4'h4;
   localparam logic [LAMP_W-1:0] LAMP_OPTION = 4'h8;
   localparam logic [LAMP_W-1:0] LAMP_ALL    = 4'hF;

   // stream payload widths
   localparam int REQ_FIELD_W = PERIOD_W + 3;
   localparam int REQ_TDATA_W = ((REQ_FIELD_W + 7) / 8) * 8;
   localparam int RSP_FIELD_W = LAMP_W + 1 + LEVEL_W;
   localparam int RSP_TDATA_W = ((RSP_FIELD_W + 7) / 8) * 8;

   // register file
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_STAGE1       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STAGE1_EARLY = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STAGE2       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_STAGE2_EARLY = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_REPEAT_LIMIT = 3'd4;

   typedef struct packed {
      logic [PERIOD_W-1:0] stage1;
      logic [PERIOD_W-1:0] stage1_early;
      logic [PERIOD_W-1:0] stage2;
      logic [PERIOD_W-1:0] stage2_early;
   } thresh_type;

endpackage

// ===== rtl/twsl_classify.sv =====
// lamp classification of the held average period against the stage thresholds
// depends on twsl_pkg
`timescale 1ns / 1ps

module twsl_classify import twsl_pkg::*; (
   input  logic [PERIOD_W-1:0] avg,
   input  logic                overflow,
   input  thresh_type          thresh,
   output logic [LAMP_W-1:0]   lamps
);

   logic yellow;
   logic green;
   logic red_warn;
   logic red_only;

   assign yellow   = avg > thresh.stage1;
   assign red_only = avg <= thresh.stage2;
   assign green    = (avg < thresh.stage1_early) && !red_only;
   assign red_warn = green && (avg <= thresh.stage2_early);

   always_comb begin
      priority if (overflow || (avg == '0)) begin
         lamps = LAMP_OPTION;
      end else if (red_only) begin
         lamps = LAMP_RED;
      end else begin
         lamps = (yellow ? LAMP_YELLOW : LAMP_NONE)
               | (green ? LAMP_GREEN : LAMP_NONE)
               | (red_warn ? LAMP_RED : LAMP_NONE);
      end
   end

endmodule

// ===== rtl/tach_window_shift_light_core.sv =====
// top level of the tach window shift light: averaging, button, dimming, stream ports
// depends on twsl_pkg and twsl_classify
`timescale 1ns / 1ps

// Takes one request per clock and returns exactly one response per request, in
// order, passing through an input register, then the averaging,
// lamp classification, button and dimming logic, then an output register. Both
// stages stall together when the response side holds off, so throughput is one
// request per cycle as long as rsp_tready is high. Every 16 periods the block
// latches a new average; lamps are classified against the held average. Threshold
// and repeat-limit registers are written through the csr port, which is always
// ready; write them only while no request is in flight.
module tach_window_shift_light_core import twsl_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // period_ticks[15:0], capture_overflow[16], button_held[17], dimmer_on[18], zeros
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // lamp_drive[3:0], reset_request[4], brightness_level[7:5]
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   // registers
   thresh_type             thresh_ff;
   logic [HOLD_W-1:0]      repeat_limit_ff;
   logic                   s1_valid_ff;
   logic [REQ_TDATA_W-1:0] s1_data_ff;
   logic                   rsp_valid_ff;
   logic [RSP_TDATA_W-1:0] rsp_data_ff;
   logic [CNT_W-1:0]       sample_count_ff;
   logic [SUM_W-1:0]       period_sum_ff;
   logic [PERIOD_W-1:0]    held_average_ff;
   logic [HOLD_W-1:0]      hold_count_ff;
   logic [LEVEL_W-1:0]     dim_level_ff;
   logic [PHASE_W-1:0]     pwm_phase_ff;

   // next values
   logic [CNT_W-1:0]       sample_count_in;
   logic [SUM_W-1:0]       period_sum_in;
   logic [PERIOD_W-1:0]    held_average_in;
   logic [HOLD_W-1:0]      hold_count_in;
   logic [LEVEL_W-1:0]     dim_level_in;
   logic [PHASE_W-1:0]     pwm_phase_in;
   logic [RSP_TDATA_W-1:0] rsp_data_in;

   logic                   advance;
   logic [PERIOD_W-1:0]    period;
   logic                   overflow;
   logic                   button;
   logic                   dimmer;
   logic [SUM_W-1:0]       sum_full;
   logic                   window_done;
   logic [LAMP_W-1:0]      class_lamps;
   logic [HOLD_W-1:0]      hold_inc;
   logic                   hold_hit;
   logic [PHASE_W-1:0]     level_mask;
   logic [LAMP_W-1:0]      lamps;
   logic                   request;

   assign advance    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign csr_ready  = 1'b1;

   assign period   = s1_data_ff[PERIOD_W-1:0];
   assign overflow = s1_data_ff[PERIOD_W];
   assign button   = s1_data_ff[PERIOD_W+1];
   assign dimmer   = s1_data_ff[PERIOD_W+2];

   // averaging window
   assign sum_full    = period_sum_ff + SUM_W'(period);
   assign window_done = sample_count_ff == CNT_W'(AVG_SAMPLES - 1);

   always_comb begin
      if (window_done) begin
         sample_count_in = '0;
         period_sum_in   = '0;
         held_average_in = sum_full[AVG_SHIFT +: PERIOD_W];
      end else begin
         sample_count_in = sample_count_ff + 1'b1;
         period_sum_in   = sum_full;
         held_average_in = held_average_ff;
      end
   end

   twsl_classify u_classify (
      .avg      (held_average_in),
      .overflow (overflow),
      .thresh   (thresh_ff),
      .lamps    (class_lamps)
   );

   // button hold counter and brightness step
   assign hold_inc = hold_count_ff + 1'b1;
   assign hold_hit = hold_inc == repeat_limit_ff;

   always_comb begin
      dim_level_in = dim_level_ff;
      if (button) begin
         if (hold_hit) begin
            hold_count_in = '0;
            if (dimmer) begin
               if (dim_level_ff >= LEVEL_W'(DIM_LEVELS - 1)) begin
                  dim_level_in = '0;
               end else begin
                  dim_level_in = dim_level_ff + 1'b1;
               end
            end
         end else begin
            hold_count_in = hold_inc;
         end
      end else if (hold_count_ff != '0) begin
         hold_count_in = hold_count_ff - 1'b1;
      end else begin
         hold_count_in = hold_count_ff;
      end
   end

   // dimming mask and lamp select
   assign level_mask   = PHASE_W'(({{PHASE_W{1'b0}}, 1'b1} << dim_level_in) - 1'b1);
   assign pwm_phase_in = pwm_phase_ff + 1'b1;
   assign request      = button && !dimmer;

   always_comb begin
      priority if (request) begin
         lamps = LAMP_ALL;
      end else if (dimmer && ((pwm_phase_ff & level_mask) != '0)) begin
         lamps = LAMP_NONE;
      end else begin
         lamps = class_lamps;
      end
   end

   assign rsp_data_in = RSP_TDATA_W'({dim_level_in, request, lamps});

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff       <= '0;
         repeat_limit_ff <= HOLD_W'(REPEAT_RESET);
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_STAGE1:       thresh_ff.stage1       <= csr_wdata;
            CSR_STAGE1_EARLY: thresh_ff.stage1_early <= csr_wdata;
            CSR_STAGE2:       thresh_ff.stage2       <= csr_wdata;
            CSR_STAGE2_EARLY: thresh_ff.stage2_early <= csr_wdata;
            CSR_REPEAT_LIMIT: repeat_limit_ff        <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // stage control and state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         sample_count_ff <= '0;
         period_sum_ff   <= '0;
         held_average_ff <= '0;
         hold_count_ff   <= '0;
         dim_level_ff    <= LEVEL_W'(LEVEL_AT_RESET);
         pwm_phase_ff    <= '0;
      end else begin
         if (req_tready) begin
            s1_valid_ff <= req_tvalid;
         end
         if (advance) begin
            rsp_valid_ff    <= 1'b1;
            sample_count_ff <= sample_count_in;
            period_sum_ff   <= period_sum_in;
            held_average_ff <= held_average_in;
            hold_count_ff   <= hold_count_in;
            dim_level_ff    <= dim_level_in;
            pwm_phase_ff    <= pwm_phase_in;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         s1_data_ff <= req_tdata;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // a reset request always comes with every lamp lit
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff[LAMP_W]) |-> (rsp_data_ff[LAMP_W-1:0] == LAMP_ALL))
      else $error("reset request without all lamps");

   // brightness level stays within the level range
   assert property (@(posedge clock) disable iff (reset)
      dim_level_ff <= LEVEL_W'(DIM_LEVELS - 1))
      else $error("brightness level out of range");

   // a released button decays the hold count by one
   assert property (@(posedge clock) disable iff (reset)
      (advance && !button && (hold_count_ff != '0))
         |=> (hold_count_ff == $past(hold_count_ff) - 1'b1))
      else $error("hold count did not decay");

   // the window count only moves when a request is processed
   assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(sample_count_ff))
      else $error("sample count moved without a request");

endmodule
